// ===== hdl/ppu_pkg.sv =====
package ppu_pkg;

  localparam int DEPTH    = 32;
  localparam int SLOT_W   = 5;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int ALPHA_W  = 8;
  localparam int FUNC_W   = 2;

  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADDED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LIVE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DONE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY = 3'd4;

  typedef struct packed {
    logic [DATA_W-1:0]        life_left;
    logic [DATA_W-1:0]        life_start;
    logic signed [DATA_W-1:0] where_x;
    logic signed [DATA_W-1:0] where_y;
    logic signed [DATA_W-1:0] velocity_x;
    logic signed [DATA_W-1:0] velocity_y;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

endpackage

// ===== hdl/ppu_mem.sv =====
module ppu_mem (
  input  logic                  clk,
  input  ppu_pkg::mem_wr_t      wr,
  input  logic [ppu_pkg::SLOT_W-1:0] rd_addr,
  output ppu_pkg::entry_t       rd_data
);
  import ppu_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/ppu_div.sv =====
module ppu_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ppu_pkg::DATA_W-1:0] num,
  input  logic [ppu_pkg::DATA_W-1:0] den,
  output logic                       done,
  output logic [ppu_pkg::ALPHA_W-1:0] quo
);
  import ppu_pkg::*;

  localparam int REM_W = DATA_W + ALPHA_W;

  logic [REM_W-1:0]  rem;
  logic [DATA_W-1:0] dsor;
  logic [2:0]        cnt;
  logic              busy;
  logic [REM_W-1:0]  trial;

  // numerator is num * 255; quotient fits 8 bits since num <= den
  assign trial = {{ALPHA_W{1'b0}}, dsor} << cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= ({{ALPHA_W{1'b0}}, num} << ALPHA_W) - {{ALPHA_W{1'b0}}, num};
        dsor <= den;
        cnt  <= 3'd7;
        quo  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem      <= rem - trial;
          quo[cnt] <= 1'b1;
        end
        if (cnt == 3'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 3'd1;
        end
      end
    end
  end

endmodule

// ===== hdl/particle_pool_update.sv =====
// An add or query item goes to S_ADD or S_QUERY. A tick walks the pool in S_SCAN: a free
// slot is skipped, a dying slot is read, multiplied and written back (S_MUL, S_UPD), and a
// reported slot adds the alpha divide (S_DIV) and the emit (S_EMIT); the closing item is
// registered in S_DONE. Each result is registered once the output register is free.
// One item is worked at a time; the next is taken at the edge after the last result is
// registered. Synchronous reset frees every slot and drops pending results.
module particle_pool_update #(
  parameter int POOL_SIZE = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ppu_pkg::FUNC_W-1:0]   func,
  input  logic [ppu_pkg::DATA_W-1:0]   new_life,
  input  logic signed [ppu_pkg::DATA_W-1:0] start_x,
  input  logic signed [ppu_pkg::DATA_W-1:0] start_y,
  input  logic signed [ppu_pkg::DATA_W-1:0] speed_x,
  input  logic signed [ppu_pkg::DATA_W-1:0] speed_y,
  input  logic [ppu_pkg::DATA_W-1:0]   elapsed,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ppu_pkg::KIND_W-1:0]   kind,
  output logic [ppu_pkg::SLOT_W-1:0]   slot,
  output logic signed [ppu_pkg::DATA_W-1:0] pos_x,
  output logic signed [ppu_pkg::DATA_W-1:0] pos_y,
  output logic [ppu_pkg::ALPHA_W-1:0]  alpha,
  output logic                         pool_empty,
  output logic                         last
);
  import ppu_pkg::*;

  // slots beyond the memory depth are never used
  localparam int SLOTS = (POOL_SIZE > DEPTH) ? DEPTH : POOL_SIZE;
  localparam int IDX_W = SLOT_W + 1;
  localparam int PROD_W = 2 * DATA_W + 1;
  localparam int SUM_W = PROD_W - 16 + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ADD   = 9'b000000010,
    S_QUERY = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_UPD   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  // held copy of the accepted item
  logic [DATA_W-1:0]        nl, dt;
  logic signed [DATA_W-1:0] sx, sy, vx, vy;

  // live bit per slot: life_left != 0; a clear bit means the slot is free
  logic [DEPTH-1:0] live;
  logic [IDX_W-1:0] idx;

  entry_t  rd_data;
  entry_t  ent;
  mem_wr_t wr;
  logic [SLOT_W-1:0] rd_addr;

  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [DATA_W-1:0] new_x, new_y;
  logic [DATA_W-1:0]        new_left;

  logic               div_start;
  logic               div_done;
  logic [ALPHA_W-1:0] quo;

  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  logic              out_free;
  logic              out_load;
  logic [SLOT_W-1:0] cur;

  assign cur      = idx[SLOT_W-1:0];
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign rd_addr  = cur;

  // a result-producing state loads the output register once it is free
  assign out_load = out_free && ((state == S_ADD) || (state == S_QUERY) ||
                                 (state == S_EMIT) || (state == S_DONE));

  ppu_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ppu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (new_left),
    .den   (ent.life_start),
    .done  (div_done),
    .quo   (quo)
  );

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  // Saturating position update: floor of product is an arithmetic shift.
  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] p,
    input logic signed [PROD_W-1:0] m
  );
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] hi, lo;
    s  = SUM_W'(p) + SUM_W'(m >>> 16);
    hi = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (s > hi) return hi[DATA_W-1:0];
    else if (s < lo) return lo[DATA_W-1:0];
    else return s[DATA_W-1:0];
  endfunction

  assign new_x    = sat_add(ent.where_x, prod_x);
  assign new_y    = sat_add(ent.where_y, prod_y);
  assign new_left = (ent.life_left > dt) ? ent.life_left - dt : '0;

  // memory write: add places a particle, update writes back the moved one
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = cur;
    wr.data = ent;
    if (state == S_ADD && out_free && free_found) begin
      wr.en   = 1'b1;
      wr.addr = free_slot;
      wr.data = '{life_left: nl, life_start: nl, where_x: sx, where_y: sy,
                  velocity_x: vx, velocity_y: vy};
    end else if (state == S_UPD) begin
      wr.en             = 1'b1;
      wr.data.life_left = new_left;
      wr.data.where_x   = new_x;
      wr.data.where_y   = new_y;
    end
  end

  assign div_start = (state == S_UPD) && (new_left != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      live      <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      // load a new item, or drop the one just taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            nl <= new_life;
            sx <= start_x;
            sy <= start_y;
            vx <= speed_x;
            vy <= speed_y;
            dt <= elapsed;
            idx <= '0;
            unique case (func)
              FUNC_ADD:   state <= S_ADD;
              FUNC_TICK:  state <= S_SCAN;
              FUNC_QUERY: state <= S_QUERY;
              default:    state <= S_IDLE; // unused code: drop the item
            endcase
          end
        end
        S_ADD: begin
          if (out_free) begin
            pos_x     <= '0;
            pos_y     <= '0;
            alpha     <= '0;
            last      <= 1'b1;
            if (free_found) begin
              live[free_slot] <= (nl != '0);
              kind       <= KIND_ADDED;
              slot       <= free_slot;
              pool_empty <= (live == '0) && (nl == '0);
            end else begin
              kind       <= KIND_FULL;
              slot       <= '0;
              pool_empty <= (live == '0);
            end
            state <= S_IDLE;
          end
        end
        S_QUERY: begin
          if (out_free) begin
            kind       <= KIND_QUERY;
            slot       <= '0;
            pos_x      <= '0;
            pos_y      <= '0;
            alpha      <= '0;
            pool_empty <= (live == '0);
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_SCAN: begin
          // skip free slots one per cycle; a live one starts its read here
          if (idx == IDX_W'(SLOTS)) begin
            state <= S_DONE;
          end else if (live[cur]) begin
            state <= S_MUL;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_MUL: begin
          ent    <= rd_data;
          prod_x <= $signed({1'b0, dt}) * rd_data.velocity_x;
          prod_y <= $signed({1'b0, dt}) * rd_data.velocity_y;
          state  <= S_UPD;
        end
        S_UPD: begin
          live[cur] <= (new_left != '0);
          ent.where_x   <= new_x;
          ent.where_y   <= new_y;
          if (new_left != '0) begin
            state <= S_DIV;
          end else begin
            // dying particle: written back, not reported
            idx   <= idx + IDX_W'(1);
            state <= S_SCAN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            kind       <= KIND_LIVE;
            slot       <= cur;
            pos_x      <= ent.where_x;
            pos_y      <= ent.where_y;
            alpha      <= quo;
            pool_empty <= 1'b0;
            last       <= 1'b0;
            idx        <= idx + IDX_W'(1);
            state      <= S_SCAN;
          end
        end
        S_DONE: begin
          if (out_free) begin
            kind       <= KIND_DONE;
            slot       <= '0;
            pos_x      <= '0;
            pos_y      <= '0;
            alpha      <= '0;
            pool_empty <= (live == '0);
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
